// File: rtl/alpc_pkg.sv
package alpc_pkg;

    localparam int unsigned ColorWidth  = 32;
    localparam int unsigned PixelWidth  = 32;
    localparam int unsigned BppWidth    = 3;
    localparam int unsigned ModeWidth   = 3;
    localparam int unsigned LayoutWidth = 9;
    localparam int unsigned CfgIdxWidth = 3;
    localparam int unsigned CfgDataWidth = LayoutWidth;
    // tdata widths rounded up to whole bytes
    localparam int unsigned InTdataWidth  = ((ColorWidth + 7) / 8) * 8;
    localparam int unsigned OutTdataWidth = ((PixelWidth + BppWidth + 7) / 8) * 8;

    typedef enum logic [ModeWidth-1:0] {
        MODE_ARGB8888 = 3'd0,
        MODE_ABGR8888 = 3'd1,
        MODE_BGRA8888 = 3'd2,
        MODE_RGBA8888 = 3'd3,
        MODE_RGB888   = 3'd4,
        MODE_RGB565   = 3'd5,
        MODE_BGR565   = 3'd6,
        MODE_FLEX     = 3'd7
    } t_mode;

    typedef enum logic [CfgIdxWidth-1:0] {
        REG_FORMAT_MODE = 3'd0,
        REG_ALPHA_LAYOUT = 3'd1,
        REG_RED_LAYOUT   = 3'd2,
        REG_GREEN_LAYOUT = 3'd3,
        REG_BLUE_LAYOUT  = 3'd4,
        REG_FLEX_BPP     = 3'd5
    } t_reg_idx;

    localparam logic [PixelWidth-1:0] AlphaForce = 32'hFF00_0000;
    localparam logic [BppWidth-1:0]   BppWord    = 3'd4;
    localparam logic [BppWidth-1:0]   Bpp888     = 3'd3;
    localparam logic [BppWidth-1:0]   Bpp565     = 3'd2;
    localparam logic [BppWidth-1:0]   FlexBppRst = 3'd4;

    typedef struct packed {
        t_mode                   format_mode;
        logic [LayoutWidth-1:0]  alpha_layout;
        logic [LayoutWidth-1:0]  red_layout;
        logic [LayoutWidth-1:0]  green_layout;
        logic [LayoutWidth-1:0]  blue_layout;
        logic [BppWidth-1:0]     flex_bpp;
    } t_cfg;

    // Top len bits of a channel byte, placed at pos; lengths above eight saturate.
    function automatic logic [PixelWidth-1:0] place_channel(
        input logic [7:0]             chan,
        input logic [LayoutWidth-1:0] layout
    );
        logic [4:0]            pos;
        logic [3:0]            len;
        logic [7:0]            v;
        logic [PixelWidth-1:0] wide;
        pos = layout[4:0];
        len = layout[8:5];
        if (len > 4'd8) begin
            len = 4'd8;
        end
        v    = chan >> (4'd8 - len);
        wide = {24'd0, v};
        if (len == 4'd0) begin
            place_channel = '0;
        end else begin
            place_channel = wide << pos;
        end
    endfunction

endpackage

// File: rtl/alpc_cfg_regs.sv
module alpc_cfg_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wen,
    input  logic [alpc_pkg::CfgIdxWidth-1:0]  i_cfg_idx,
    input  logic [alpc_pkg::CfgDataWidth-1:0] i_cfg_data,
    output alpc_pkg::t_cfg                    o_cfg
);
    import alpc_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_wen) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_FORMAT_MODE:  n_cfg.format_mode  = t_mode'(i_cfg_data[ModeWidth-1:0]);
                REG_ALPHA_LAYOUT: n_cfg.alpha_layout = i_cfg_data;
                REG_RED_LAYOUT:   n_cfg.red_layout   = i_cfg_data;
                REG_GREEN_LAYOUT: n_cfg.green_layout = i_cfg_data;
                REG_BLUE_LAYOUT:  n_cfg.blue_layout  = i_cfg_data;
                REG_FLEX_BPP:     n_cfg.flex_bpp     = i_cfg_data[BppWidth-1:0];
                default:          n_cfg = r_cfg; // drop writes past the register list
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.format_mode  <= MODE_ARGB8888;
            r_cfg.alpha_layout <= '0;
            r_cfg.red_layout   <= '0;
            r_cfg.green_layout <= '0;
            r_cfg.blue_layout  <= '0;
            r_cfg.flex_bpp     <= FlexBppRst;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: rtl/alpc_encode.sv
module alpc_encode (
    input  logic [alpc_pkg::ColorWidth-1:0] i_color,
    input  alpc_pkg::t_cfg                  i_cfg,
    output logic [alpc_pkg::PixelWidth-1:0] o_pixel,
    output logic [alpc_pkg::BppWidth-1:0]   o_bpp
);
    import alpc_pkg::*;

    logic [7:0]            alpha;
    logic [7:0]            red;
    logic [7:0]            green;
    logic [7:0]            blue;
    logic [PixelWidth-1:0] flex_pixel;

    assign alpha = i_color[31:24];
    assign red   = i_color[23:16];
    assign green = i_color[15:8];
    assign blue  = i_color[7:0];

    // overlapping channels simply OR together
    assign flex_pixel = place_channel(alpha, i_cfg.alpha_layout)
                      | place_channel(red,   i_cfg.red_layout)
                      | place_channel(green, i_cfg.green_layout)
                      | place_channel(blue,  i_cfg.blue_layout);

    always_comb begin
        case (i_cfg.format_mode)
            MODE_FLEX: begin
                o_pixel = flex_pixel;
                o_bpp   = i_cfg.flex_bpp;
            end
            // BGR565 keeps red on top, same as RGB565
            MODE_RGB565, MODE_BGR565: begin
                o_pixel = {16'd0, red[7:3], green[7:2], blue[7:3]};
                o_bpp   = Bpp565;
            end
            MODE_RGB888: begin
                o_pixel = {8'd0, blue, green, red};
                o_bpp   = Bpp888;
            end
            default: begin
                o_pixel = i_color | AlphaForce;
                o_bpp   = BppWord;
            end
        endcase
    end

endmodule

// File: rtl/argb_to_layer_pixel_converter.sv
// ARGB8888 to layer pixel converter.
// Slave stream s_axis_*: one ARGB8888 colour per item (alpha 31..24 .. blue 7..0).
// Master stream m_axis_*: the pixel word in the programmed layer format, right
// aligned, with the bytes per pixel of that format in tdata bits 34..32.
// Configuration: i_cfg_wen writes i_cfg_data into register i_cfg_idx at the clock
// edge (0 format mode, 1..4 alpha/red/green/blue layout, 5 flexible byte count);
// indexes past 5 are ignored. Write only while the stream is drained.
// Path: an accepted item is held in the input register, then passes through the
// conversion logic into the result register, which drives m_axis_tvalid.
// Throughput: one item per clock while not stalled; the conversion is a single
// pass of byte selects and four small barrel shifters between the two registers.
// Stall: while the result register is full and not taken, the input register
// still accepts one item; s_axis_tready drops only when both are occupied.
// Reset (i_rst_n low, synchronous) empties both registers and restores the
// register defaults: ARGB8888, all layouts zero, flexible byte count four.
module argb_to_layer_pixel_converter (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration write port
    input  logic                               i_cfg_wen,
    input  logic [alpc_pkg::CfgIdxWidth-1:0]   i_cfg_idx,
    input  logic [alpc_pkg::CfgDataWidth-1:0]  i_cfg_data,
    // colour items
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [alpc_pkg::InTdataWidth-1:0]  s_axis_tdata,  // [31:0] argb_color
    // pixel items
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [alpc_pkg::OutTdataWidth-1:0] m_axis_tdata   // [31:0] pixel_word,
                                                              // [34:32] pixel_bytes
);
    import alpc_pkg::*;

    t_cfg                  cfg;
    logic                  r_in_valid;
    logic [ColorWidth-1:0] r_color;
    logic                  r_out_valid;
    logic [PixelWidth-1:0] r_pixel;
    logic [BppWidth-1:0]   r_bpp;
    logic [PixelWidth-1:0] n_pixel;
    logic [BppWidth-1:0]   n_bpp;
    logic                  advance;
    logic                  in_take;

    alpc_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_wen  (i_cfg_wen),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    alpc_encode u_encode (
        .i_color (r_color),
        .i_cfg   (cfg),
        .o_pixel (n_pixel),
        .o_bpp   (n_bpp)
    );

    // result register free or being emptied this cycle
    assign advance       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_color <= s_axis_tdata[ColorWidth-1:0];
        end
        if (advance && r_in_valid) begin
            r_pixel <= n_pixel;
            r_bpp   <= n_bpp;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OutTdataWidth - PixelWidth - BppWidth){1'b0}}, r_bpp, r_pixel};

endmodule

// File: rtl/alpc_port_chk.sv
module alpc_port_chk (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               s_axis_tvalid,
    input logic                               s_axis_tready,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    input logic [alpc_pkg::OutTdataWidth-1:0] m_axis_tdata
);
    import alpc_pkg::*;

    // a stalled result holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed or vanished");

    // an accepted item must have raised m_axis_tvalid once it has passed both registers
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> ##1 m_axis_tvalid)
        else $error("accepted item not presented after two cycles");

    // input back-pressure only when the output side is stalled
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output stall");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[OutTdataWidth-1:PixelWidth+BppWidth] == '0)
        else $error("tdata padding not zero");

endmodule

bind argb_to_layer_pixel_converter alpc_port_chk u_port_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// File: bench/tb_argb_to_layer_pixel_converter.sv
module tb_argb_to_layer_pixel_converter;
    timeunit 1ns;
    timeprecision 1ps;

    import alpc_pkg::*;

    localparam int unsigned RandomItems    = 600;
    localparam int unsigned QuietTailItems = 100;
    localparam int unsigned DrainCycles    = 4;
    localparam int unsigned WatchdogLimit  = 2000;
    localparam int unsigned MaxReports     = 10;

    // indexes past the register list; writes there must be ignored
    localparam logic [CfgIdxWidth-1:0] RegSpareLow  = 3'd6;
    localparam logic [CfgIdxWidth-1:0] RegSpareHigh = 3'd7;

    typedef struct packed {
        logic [PixelWidth-1:0] pixel_word;
        logic [BppWidth-1:0]   pixel_bytes;
    } t_pixel_item;

    class pixel_scoreboard;
        t_mode                  mode;
        logic [LayoutWidth-1:0] alpha_layout;
        logic [LayoutWidth-1:0] red_layout;
        logic [LayoutWidth-1:0] green_layout;
        logic [LayoutWidth-1:0] blue_layout;
        logic [BppWidth-1:0]    flex_bpp;
        t_pixel_item            expected_pixels[$];
        int unsigned            colours_noted;
        int unsigned            pixels_checked;
        int unsigned            mismatches;
        logic [7:0]             modes_seen;

        function new();
            mode          = MODE_ARGB8888;
            alpha_layout  = '0;
            red_layout    = '0;
            green_layout  = '0;
            blue_layout   = '0;
            flex_bpp      = FlexBppRst;
            colours_noted = 0;
            pixels_checked = 0;
            mismatches    = 0;
            modes_seen    = '0;
        endfunction

        function void write_register(logic [CfgIdxWidth-1:0] idx,
                                     logic [CfgDataWidth-1:0] data);
            case (idx)
                REG_FORMAT_MODE:  mode = t_mode'(data[ModeWidth-1:0]);
                REG_ALPHA_LAYOUT: alpha_layout = data;
                REG_RED_LAYOUT:   red_layout = data;
                REG_GREEN_LAYOUT: green_layout = data;
                REG_BLUE_LAYOUT:  blue_layout = data;
                REG_FLEX_BPP:     flex_bpp = data[BppWidth-1:0];
                default: ;
            endcase
        endfunction

        // Keep the top len bits of the channel byte and move them to pos;
        // bits pushed past bit 31 fall off.
        function logic [PixelWidth-1:0] channel_bits(logic [7:0] chan,
                                                     logic [LayoutWidth-1:0] layout);
            int unsigned           len;
            logic [PixelWidth-1:0] field;
            len = 32'(layout[8:5]);
            if (len == 0) begin
                return '0;
            end
            if (len > 8) begin
                len = 8;
            end
            field = {24'd0, chan} >> (8 - len);
            return field << layout[4:0];
        endfunction

        function t_pixel_item convert(logic [ColorWidth-1:0] argb);
            t_pixel_item item;
            case (mode)
                MODE_FLEX: begin
                    item.pixel_word = channel_bits(argb[31:24], alpha_layout)
                                    | channel_bits(argb[23:16], red_layout)
                                    | channel_bits(argb[15:8], green_layout)
                                    | channel_bits(argb[7:0], blue_layout);
                    item.pixel_bytes = flex_bpp;
                end
                // both 565 layouts put red on top
                MODE_RGB565, MODE_BGR565: begin
                    item.pixel_word = {16'd0, argb[23:19], argb[15:10], argb[7:3]};
                    item.pixel_bytes = Bpp565;
                end
                MODE_RGB888: begin
                    item.pixel_word = {8'd0, argb[7:0], argb[15:8], argb[23:16]};
                    item.pixel_bytes = Bpp888;
                end
                default: begin
                    item.pixel_word = argb | AlphaForce;
                    item.pixel_bytes = BppWord;
                end
            endcase
            return item;
        endfunction

        function void note_colour(logic [ColorWidth-1:0] argb);
            expected_pixels.push_back(convert(argb));
            modes_seen[mode] = 1'b1;
            colours_noted++;
        endfunction

        function void check_pixel(logic [PixelWidth-1:0] pixel_word,
                                  logic [BppWidth-1:0] pixel_bytes);
            t_pixel_item want;
            pixels_checked++;
            if (expected_pixels.size() == 0) begin
                mismatches++;
                if (mismatches <= MaxReports) begin
                    $display("%0t: unexpected pixel item %08h bpp %0d", $realtime,
                             pixel_word, pixel_bytes);
                end
                return;
            end
            want = expected_pixels.pop_front();
            if (pixel_word !== want.pixel_word
                    || pixel_bytes !== want.pixel_bytes) begin
                mismatches++;
                if (mismatches <= MaxReports) begin
                    $display("%0t: pixel %0d: pixel_word exp %08h got %08h, bpp exp %0d got %0d",
                             $realtime, pixels_checked, want.pixel_word, pixel_word,
                             want.pixel_bytes, pixel_bytes);
                end
            end
        endfunction

        function int unsigned pending();
            return expected_pixels.size();
        endfunction
    endclass

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_wen = 1'b0;
    logic [CfgIdxWidth-1:0]   i_cfg_idx = '0;
    logic [CfgDataWidth-1:0]  i_cfg_data = '0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [InTdataWidth-1:0]  s_axis_tdata = '0;   // [31:0] argb_color
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic [OutTdataWidth-1:0] m_axis_tdata;        // [31:0] pixel_word,
                                                   // [34:32] pixel_bytes

    pixel_scoreboard converter_model = new();
    bit              quiet_tail = 1'b0;
    int unsigned     settings_used = 0;
    int unsigned     idle_cycles = 0;

    argb_to_layer_pixel_converter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic logic [LayoutWidth-1:0] layout_word(int unsigned len,
                                                           int unsigned pos);
        return {len[3:0], pos[4:0]};
    endfunction

    function automatic logic [ColorWidth-1:0] random_colour();
        logic [ColorWidth-1:0] one_bit;
        one_bit = 32'd1 << $urandom_range(0, 31);
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return one_bit;
            3: return ~one_bit;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [LayoutWidth-1:0] random_layout();
        if ($urandom_range(0, 1) == 0) begin
            return 9'($urandom_range(0, 511));
        end
        return layout_word($urandom_range(1, 8), $urandom_range(0, 24));
    endfunction

    // Drive the write up to a rising clock edge; the caller drops the enable after the last one.
    task automatic write_reg(input logic [CfgIdxWidth-1:0] idx,
                             input logic [CfgDataWidth-1:0] data);
        i_cfg_wen  <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        converter_model.write_register(idx, data);
    endtask

    task automatic program_layer(input logic [CfgDataWidth-1:0] mode_word,
                                 input logic [CfgDataWidth-1:0] alpha,
                                 input logic [CfgDataWidth-1:0] red,
                                 input logic [CfgDataWidth-1:0] green,
                                 input logic [CfgDataWidth-1:0] blue,
                                 input logic [CfgDataWidth-1:0] bpp_word,
                                 input bit with_spare);
        while (converter_model.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (DrainCycles) @(posedge i_clk);
        write_reg(REG_FORMAT_MODE, mode_word);
        write_reg(REG_ALPHA_LAYOUT, alpha);
        write_reg(REG_RED_LAYOUT, red);
        write_reg(REG_GREEN_LAYOUT, green);
        write_reg(REG_BLUE_LAYOUT, blue);
        write_reg(REG_FLEX_BPP, bpp_word);
        if (with_spare) begin
            write_reg(RegSpareLow, 9'($urandom_range(0, 511)));
            write_reg(RegSpareHigh, 9'($urandom_range(0, 511)));
        end
        i_cfg_wen <= 1'b0;
        settings_used++;
    endtask

    task automatic send_colour(input logic [ColorWidth-1:0] argb);
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= argb;
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        converter_model.note_colour(argb);
    endtask

    task automatic send_pair(input logic [ColorWidth-1:0] first,
                             input logic [ColorWidth-1:0] second);
        send_colour(first);
        send_colour(second);
        s_axis_tvalid <= 1'b0;
    endtask

    // Result side: ready in runs, broken by stall bursts until the tail.
    initial begin
        forever begin
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge i_clk);
            if (!quiet_tail && $urandom_range(0, 2) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            converter_model.check_pixel(m_axis_tdata[31:0], m_axis_tdata[34:32]);
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WatchdogLimit) begin
            $display("Watchdog: %0d cycles without progress, %0d pixels outstanding",
                     idle_cycles, converter_model.pending());
            $display("FAIL argb_to_layer_pixel_converter");
            $finish;
        end
    end

    initial begin
        int unsigned items_left;
        int unsigned run_len;
        logic [2:0]  mode_pick;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset defaults: ARGB8888 with alpha forced
        send_pair(32'h0000_0000, 32'hFFFF_FFFF);

        for (int m = MODE_ABGR8888; m <= MODE_BGR565; m++) begin
            // upper data bits on a mode write are dropped by the register
            program_layer((m == MODE_RGB565) ? {6'b111111, MODE_RGB565} : {6'd0, m[2:0]},
                          '0, '0, '0, '0, {6'd0, FlexBppRst}, 1'b0);
            send_pair(32'h80FF_7F01, 32'h7F00_80FE);
        end

        // usual 565-like flexible layout, blue omitted by zero length
        program_layer({6'd0, MODE_FLEX}, layout_word(8, 24), layout_word(5, 11),
                      layout_word(6, 5), layout_word(0, 0), 9'd2, 1'b0);
        send_pair(32'hFFFF_FFFF, 32'h1234_5678);

        // saturated lengths at bit 31: only channel bit 0 survives, all ORed
        program_layer({6'd0, MODE_FLEX}, 9'h1FF, 9'h1FF, 9'h1FF, 9'h1FF, 9'd7, 1'b0);
        send_pair(32'h0100_0000, 32'h0000_0001);

        // overlapping channels, byte count zero, spare indexes written
        program_layer({6'd0, MODE_FLEX}, layout_word(4, 4), layout_word(4, 4),
                      layout_word(4, 4), layout_word(4, 4), 9'd0, 1'b1);
        send_pair(32'h1020_4080, 32'hF000_0000);

        program_layer({6'd0, MODE_FLEX}, '0, '0, '0, '0, 9'd0, 1'b0);
        send_colour(32'hFFFF_FFFF);
        s_axis_tvalid <= 1'b0;

        items_left = RandomItems;
        while (items_left > 0) begin
            if (items_left <= QuietTailItems) begin
                quiet_tail = 1'b1;
            end
            mode_pick = ($urandom_range(0, 1) == 0) ? MODE_FLEX : 3'($urandom_range(0, 6));
            program_layer({6'($urandom_range(0, 63)), mode_pick}, random_layout(),
                          random_layout(), random_layout(), random_layout(),
                          9'($urandom_range(0, 511)), $urandom_range(0, 3) == 0);
            run_len = $urandom_range(10, 60);
            if (run_len > items_left) begin
                run_len = items_left;
            end
            repeat (run_len) send_colour(random_colour());
            s_axis_tvalid <= 1'b0;
            items_left -= run_len;
        end

        while (converter_model.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (DrainCycles) @(posedge i_clk);

        $display("Converted %0d colours under %0d register settings, formats seen %08b",
                 converter_model.colours_noted, settings_used, converter_model.modes_seen);
        $display("%0d pixel items checked, %0d mismatches, %0d still outstanding",
                 converter_model.pixels_checked, converter_model.mismatches,
                 converter_model.pending());
        if (converter_model.mismatches == 0 && converter_model.pending() == 0) begin
            $display("PASS argb_to_layer_pixel_converter");
        end else begin
            $display("FAIL argb_to_layer_pixel_converter");
        end
        $finish;
    end

endmodule
